// ===== src/bst_pkg.sv =====
// bst_pkg: shared widths, stage counts, stream word types and the square-root step
// used by the bounding sphere transform pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bst_pkg;

    localparam int NUM_LANES           = 3;
    localparam int FIELD_WIDTH         = 48;
    localparam int RADIUS_WIDTH        = 16;
    // squared column length is normalized so the root carries this many bits
    localparam int ROOT_SCALE_BITS     = 31;
    localparam int ROOT_WIDTH          = 32;
    localparam int RADICAND_WIDTH      = 2 * ROOT_WIDTH;
    localparam int REM_WIDTH           = ROOT_WIDTH + 3;
    localparam int SQRT_BITS_PER_STAGE = 2;
    localparam int SQRT_STAGES         = ROOT_WIDTH / SQRT_BITS_PER_STAGE;
    // index of the stage that holds the finished root
    localparam int ROOT_STAGE          = 2 + SQRT_STAGES;
    localparam int NUM_STAGES          = ROOT_STAGE + 3;

    localparam logic [RADIUS_WIDTH-1:0] RADIUS_MAX = '1;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0]  matrix_column_0;
        logic [FIELD_WIDTH-1:0]  matrix_column_1;
        logic [FIELD_WIDTH-1:0]  matrix_column_2;
        logic [FIELD_WIDTH-1:0]  translation_column;
        logic [FIELD_WIDTH-1:0]  sphere_center;
        logic [RADIUS_WIDTH-1:0] sphere_radius;
    } t_in_word;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0]  new_center;
        logic [RADIUS_WIDTH-1:0] new_radius;
        logic                    saturated;
    } t_out_word;

    typedef struct packed {
        logic [ROOT_WIDTH-1:0] root;
        logic [REM_WIDTH-1:0]  rem;
    } t_sqrt_acc;

    // one restoring digit of the integer square root
    function automatic t_sqrt_acc sqrt_step(t_sqrt_acc acc, logic [1:0] pair);
        logic [REM_WIDTH-1:0] rem_sh;
        logic [REM_WIDTH-1:0] trial;
        t_sqrt_acc            res;
        rem_sh = {acc.rem[REM_WIDTH-3:0], pair};
        trial  = REM_WIDTH'({acc.root, 2'b01});
        if (rem_sh >= trial) begin
            res.rem  = rem_sh - trial;
            res.root = {acc.root[ROOT_WIDTH-2:0], 1'b1};
        end else begin
            res.rem  = rem_sh;
            res.root = {acc.root[ROOT_WIDTH-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/bst_stream_if.sv =====
// bst_stream_if: valid/ready stream channel carrying one word of type T.
// No dependencies; the word type is chosen where the channel is instantiated.
`timescale 1ns / 1ps
`default_nettype none

interface bst_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/bst_center.sv =====
// bst_center: center path, matrix times (c, 1) with rounding and lane saturation,
// then a delay line to the output stage. Depends on bst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bst_center import bst_pkg::*; #(
    parameter int VALUE_WIDTH          = 16,
    parameter int MATRIX_FRACTION_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [VALUE_WIDTH-1:0] i_m [NUM_LANES][NUM_LANES],
    input  logic signed [VALUE_WIDTH-1:0] i_t [NUM_LANES],
    input  logic signed [VALUE_WIDTH-1:0] i_c [NUM_LANES],
    output logic [FIELD_WIDTH-1:0]        o_center,
    output logic                          o_sat
);

    localparam int VW     = VALUE_WIDTH;
    localparam int FB     = MATRIX_FRACTION_BITS;
    localparam int PROD_W = 2 * VW;
    localparam int ACC_W  = ((2 * VW > VW + FB) ? 2 * VW : VW + FB) + 2;
    localparam int PACK_W = NUM_LANES * VW;
    localparam int EXT_W  = (PACK_W > FIELD_WIDTH) ? PACK_W : FIELD_WIDTH;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (FB - 1));
    localparam logic signed [ACC_W-1:0] LANE_MAX   = ACC_W'((2 ** (VW - 1)) - 1);
    localparam logic signed [ACC_W-1:0] LANE_MIN   = ~LANE_MAX;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] ctr;
        logic                   sat;
    } t_ctr_word;

    logic signed [PROD_W-1:0] r_prod [NUM_LANES][NUM_LANES];
    logic signed [VW-1:0]     r_t    [NUM_LANES];
    logic signed [ACC_W-1:0]  r_acc  [NUM_LANES];
    logic signed [ACC_W-1:0]  n_acc  [NUM_LANES];
    logic signed [ACC_W-1:0]  w_round [NUM_LANES];
    logic [VW-1:0]            w_lane [NUM_LANES];
    logic [EXT_W-1:0]         w_pack;
    t_ctr_word                n_word;
    t_ctr_word                r_line [2:NUM_STAGES-1];

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            n_acc[i] = (ACC_W'(r_t[i]) <<< FB)
                     + ACC_W'(r_prod[i][0]) + ACC_W'(r_prod[i][1]) + ACC_W'(r_prod[i][2]);
        end
    end

    always_comb begin
        w_pack     = '0;
        n_word.sat = 1'b0;
        for (int i = 0; i < NUM_LANES; i++) begin
            // round half up, then clip to the lane range
            w_round[i] = (r_acc[i] + ROUND_HALF) >>> FB;
            if (w_round[i] > LANE_MAX) begin
                w_lane[i]  = LANE_MAX[VW-1:0];
                n_word.sat = 1'b1;
            end else if (w_round[i] < LANE_MIN) begin
                w_lane[i]  = LANE_MIN[VW-1:0];
                n_word.sat = 1'b1;
            end else begin
                w_lane[i]  = w_round[i][VW-1:0];
            end
            w_pack[i*VW +: VW] = w_lane[i];
        end
        n_word.ctr = w_pack[FIELD_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                r_t[i] <= i_t[i];
                for (int j = 0; j < NUM_LANES; j++) begin
                    r_prod[i][j] <= PROD_W'(i_m[j][i]) * PROD_W'(i_c[j]);
                end
                r_acc[i] <= n_acc[i];
            end
            r_line[2] <= n_word;
            for (int k = 3; k < NUM_STAGES; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_center = r_line[NUM_STAGES-1].ctr;
    assign o_sat    = r_line[NUM_STAGES-1].sat;

endmodule

`default_nettype wire

// ===== src/bst_scale.sv =====
// bst_scale: squared column lengths of the 3x3 part, their maximum, and the
// normalized radicand for the root pipeline. Depends on bst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bst_scale import bst_pkg::*; #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [VALUE_WIDTH-1:0] i_m [NUM_LANES][NUM_LANES],
    output logic [RADICAND_WIDTH-1:0]     o_radicand
);

    localparam int PROD_W    = 2 * VALUE_WIDTH;
    localparam int RAD_SHIFT = 2 * (ROOT_SCALE_BITS - VALUE_WIDTH);

    logic signed [PROD_W-1:0]  w_sq   [NUM_LANES][NUM_LANES];
    logic [PROD_W-1:0]         r_sq   [NUM_LANES][NUM_LANES];
    logic [PROD_W-1:0]         r_colsum [NUM_LANES];
    logic [PROD_W-1:0]         w_max;
    logic [RADICAND_WIDTH-1:0] r_radicand;

    always_comb begin
        for (int j = 0; j < NUM_LANES; j++) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                w_sq[j][i] = PROD_W'(i_m[j][i]) * PROD_W'(i_m[j][i]);
            end
        end
    end

    always_comb begin
        w_max = r_colsum[0];
        for (int j = 1; j < NUM_LANES; j++) begin
            if (r_colsum[j] > w_max) begin
                w_max = r_colsum[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < NUM_LANES; j++) begin
                for (int i = 0; i < NUM_LANES; i++) begin
                    r_sq[j][i] <= w_sq[j][i];
                end
                // three squares of at most 2^(2w-2) stay below 2^(2w)
                r_colsum[j] <= r_sq[j][0] + r_sq[j][1] + r_sq[j][2];
            end
            r_radicand <= RADICAND_WIDTH'(w_max) << RAD_SHIFT;
        end
    end

    assign o_radicand = r_radicand;

endmodule

`default_nettype wire

// ===== src/bst_sqrt.sv =====
// bst_sqrt: pipelined integer square root, two root bits per stage.
// Depends on bst_pkg (sqrt_step, stage counts).
`timescale 1ns / 1ps
`default_nettype none

module bst_sqrt import bst_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [RADICAND_WIDTH-1:0] i_radicand,
    output logic [ROOT_WIDTH-1:0]     o_root
);

    logic [RADICAND_WIDTH-1:0] r_x   [SQRT_STAGES];
    t_sqrt_acc                 r_acc [SQRT_STAGES];
    logic [RADICAND_WIDTH-1:0] n_x   [SQRT_STAGES];
    t_sqrt_acc                 n_acc [SQRT_STAGES];

    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
        always_comb begin
            logic [RADICAND_WIDTH-1:0] x;
            t_sqrt_acc                 acc;
            if (s == 0) begin
                x   = i_radicand;
                acc = '0;
            end else begin
                x   = r_x[(s > 0) ? s - 1 : 0];
                acc = r_acc[(s > 0) ? s - 1 : 0];
            end
            // consume the radicand from the top, one bit pair per digit
            for (int b = 0; b < SQRT_BITS_PER_STAGE; b++) begin
                acc = sqrt_step(acc, x[RADICAND_WIDTH-1 -: 2]);
                x   = x << 2;
            end
            n_x[s]   = x;
            n_acc[s] = acc;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[s]   <= n_x[s];
                r_acc[s] <= n_acc[s];
            end
        end
    end

    assign o_root = r_acc[SQRT_STAGES-1].root;

endmodule

`default_nettype wire

// ===== src/bst_radius.sv =====
// bst_radius: radius delay line, root times radius, rounding and saturation to Q8.8.
// Depends on bst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bst_radius import bst_pkg::*; #(
    parameter int VALUE_WIDTH          = 16,
    parameter int MATRIX_FRACTION_BITS = 12
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [RADIUS_WIDTH-1:0] i_radius,
    input  logic [ROOT_WIDTH-1:0]   i_root,
    output logic [RADIUS_WIDTH-1:0] o_radius,
    output logic                    o_sat
);

    localparam int PROD_W = ROOT_WIDTH + RADIUS_WIDTH;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SH     = MATRIX_FRACTION_BITS + ROOT_SCALE_BITS - VALUE_WIDTH;

    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (SH - 1);

    logic [RADIUS_WIDTH-1:0] r_line [0:ROOT_STAGE];
    logic [PROD_W-1:0]       r_prod;
    logic [SUM_W-1:0]        w_q;
    logic [RADIUS_WIDTH-1:0] n_radius;
    logic                    n_sat;
    logic [RADIUS_WIDTH-1:0] r_radius;
    logic                    r_sat;

    always_comb begin
        w_q = (SUM_W'(r_prod) + ROUND_HALF) >> SH;
        if (w_q > SUM_W'(RADIUS_MAX)) begin
            n_radius = RADIUS_MAX;
            n_sat    = 1'b1;
        end else begin
            n_radius = w_q[RADIUS_WIDTH-1:0];
            n_sat    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_radius;
            for (int k = 1; k <= ROOT_STAGE; k++) begin
                r_line[k] <= r_line[k-1];
            end
            r_prod   <= PROD_W'(i_root) * PROD_W'(r_line[ROOT_STAGE]);
            r_radius <= n_radius;
            r_sat    <= n_sat;
        end
    end

    assign o_radius = r_radius;
    assign o_sat    = r_sat;

endmodule

`default_nettype wire

// ===== src/bounding_sphere_transform_core.sv =====
// bounding_sphere_transform_core: top level, lane unpacking, valid pipeline and
// output skid register. Depends on bst_pkg, bst_stream_if and the bst_* stages.
//
//   channel  dir  word        contents
//   i_in     in   t_in_word   three matrix columns, translation, center, radius
//   o_out    out  t_out_word  new center, new radius, saturated flag
//
// one sphere per cycle while the skid register is empty; the 16-stage square root (two root
// bits per stage) sets the depth, between 3 front stages and 2 radius stages
// reset clears the valid bits and the skid valid flag; the data path registers are not reset
// a skid register behind the last stage takes one word while o_out is stalled;
// i_in.ready falls while it is full and the whole pipeline holds
`timescale 1ns / 1ps
`default_nettype none

module bounding_sphere_transform_core import bst_pkg::*; #(
    parameter int VALUE_WIDTH          = 16,
    parameter int MATRIX_FRACTION_BITS = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bst_stream_if.sink    i_in,
    bst_stream_if.source  o_out
);

    localparam int VW     = VALUE_WIDTH;
    localparam int PACK_W = NUM_LANES * VW;
    localparam int EXT_W  = (PACK_W > FIELD_WIDTH) ? PACK_W : FIELD_WIDTH;
    localparam int NUM_FIELDS = NUM_LANES + 2;

    logic [FIELD_WIDTH-1:0]  w_field [NUM_FIELDS];
    logic [EXT_W-1:0]        w_ext   [NUM_FIELDS];
    logic signed [VW-1:0]    w_m     [NUM_LANES][NUM_LANES];
    logic signed [VW-1:0]    w_t     [NUM_LANES];
    logic signed [VW-1:0]    w_c     [NUM_LANES];

    logic                      w_en;
    logic [NUM_STAGES-1:0]     r_v;
    logic                      r_skid_v;
    t_out_word                 r_skid;
    t_out_word                 w_last;
    logic [RADICAND_WIDTH-1:0] w_radicand;
    logic [ROOT_WIDTH-1:0]     w_root;
    logic [FIELD_WIDTH-1:0]    w_ctr;
    logic                      w_ctr_sat;
    logic [RADIUS_WIDTH-1:0]   w_rad;
    logic                      w_rad_sat;

    assign w_field[0] = i_in.data.matrix_column_0;
    assign w_field[1] = i_in.data.matrix_column_1;
    assign w_field[2] = i_in.data.matrix_column_2;
    assign w_field[3] = i_in.data.translation_column;
    assign w_field[4] = i_in.data.sphere_center;

    // lanes past bit 47 read as zero when three lanes do not fit
    always_comb begin
        for (int f = 0; f < NUM_FIELDS; f++) begin
            w_ext[f] = EXT_W'(w_field[f]);
        end
        for (int i = 0; i < NUM_LANES; i++) begin
            for (int j = 0; j < NUM_LANES; j++) begin
                w_m[j][i] = w_ext[j][i*VW +: VW];
            end
            w_t[i] = w_ext[NUM_LANES][i*VW +: VW];
            w_c[i] = w_ext[NUM_LANES+1][i*VW +: VW];
        end
    end

    // every stage advances together while the skid register is empty
    assign w_en       = !r_skid_v;
    assign i_in.ready = w_en;

    bst_center #(
        .VALUE_WIDTH          (VALUE_WIDTH),
        .MATRIX_FRACTION_BITS (MATRIX_FRACTION_BITS)
    ) u_center (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_m      (w_m),
        .i_t      (w_t),
        .i_c      (w_c),
        .o_center (w_ctr),
        .o_sat    (w_ctr_sat)
    );

    bst_scale #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_scale (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_m        (w_m),
        .o_radicand (w_radicand)
    );

    bst_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_radicand (w_radicand),
        .o_root     (w_root)
    );

    bst_radius #(
        .VALUE_WIDTH          (VALUE_WIDTH),
        .MATRIX_FRACTION_BITS (MATRIX_FRACTION_BITS)
    ) u_radius (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_radius (i_in.data.sphere_radius),
        .i_root   (w_root),
        .o_radius (w_rad),
        .o_sat    (w_rad_sat)
    );

    assign w_last.new_center = w_ctr;
    assign w_last.new_radius = w_rad;
    assign w_last.saturated  = w_ctr_sat | w_rad_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= '0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_en) begin
                r_v <= {r_v[NUM_STAGES-2:0], i_in.valid};
            end
            if (r_skid_v) begin
                if (o_out.ready) begin
                    r_skid_v <= 1'b0;
                end
            end else if (r_v[NUM_STAGES-1] && !o_out.ready) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            r_skid <= w_last;
        end
    end

    assign o_out.valid = r_skid_v | r_v[NUM_STAGES-1];
    assign o_out.data  = r_skid_v ? r_skid : w_last;

`ifndef SYNTHESIS
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v && !o_out.ready |=> r_skid_v && $stable(r_skid))
        else $error("skid word changed while stalled");

    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |=> $stable(r_v))
        else $error("pipeline moved while skid register full");

    a_entry_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v[0]) |-> $past(i_in.valid && i_in.ready))
        else $error("first stage became valid without an accepted word");

    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_v[NUM_STAGES-1] && !o_out.ready))
        else $error("skid register filled without a stalled result");
`endif

endmodule

`default_nettype wire

// ===== test/bounding_sphere_transform_core_tb.sv =====
// bounding_sphere_transform_core_tb: self-checking bench for the sphere transform pipeline.
// Depends on bst_pkg, bst_stream_if and bounding_sphere_transform_core from src.
// A local fixed-point predictor is checked word by word under random idling and back-pressure.
`timescale 1ns / 1ps

module bounding_sphere_transform_core_tb;
    import bst_pkg::*;

    localparam int TB_VALUE_WIDTH  = 16;
    localparam int TB_MATRIX_FRAC  = 12;
    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 12;
    localparam int DRAIN_CYCLES    = 40;
    localparam int LONG_HOLD       = 300;
    localparam int CYCLE_LIMIT     = 900000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bst_stream_if #(.T(t_in_word))  in_if ();
    bst_stream_if #(.T(t_out_word)) out_if ();

    bounding_sphere_transform_core #(
        .VALUE_WIDTH          (TB_VALUE_WIDTH),
        .MATRIX_FRACTION_BITS (TB_MATRIX_FRAC)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_out_word   pending_spheres[$];
    int unsigned spheres_sent;
    int unsigned spheres_checked;
    int unsigned clipped_seen;
    int unsigned mismatch_count;
    int unsigned cycle_count;
    bit          idle_on;
    bit          long_hold_req;

    // ---------------------------------------------------------------- predictor

    function automatic longint lane_value(logic [FIELD_WIDTH-1:0] field, int k);
        logic [63:0]               wide;
        logic [TB_VALUE_WIDTH-1:0] u;
        wide = 64'(field) >> (k * TB_VALUE_WIDTH);
        u    = wide[TB_VALUE_WIDTH-1:0];
        return longint'(signed'(u));
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        for (int k = 31; k >= 0; k--) begin
            b = r | (64'd1 << k);
            if (b * b <= x) r = b;
        end
        return r;
    endfunction

    function automatic t_out_word transform_sphere(t_in_word w);
        longint          m[3][3];
        longint          t[3];
        longint          c[3];
        longint          acc;
        longint          r;
        longint          lane_max;
        longint          lane_min;
        longint unsigned lane_mask;
        longint unsigned packed_ctr;
        longint unsigned col_sq;
        longint unsigned max_sq;
        longint unsigned root;
        longint unsigned prod;
        longint unsigned rad;
        int              sh;
        bit              clip;
        t_out_word       res;
        lane_max   = (64'sd1 <<< (TB_VALUE_WIDTH - 1)) - 1;
        lane_min   = -lane_max - 1;
        lane_mask  = (64'd1 << TB_VALUE_WIDTH) - 1;
        packed_ctr = 0;
        max_sq     = 0;
        clip       = 1'b0;
        for (int i = 0; i < 3; i++) begin
            m[0][i] = lane_value(w.matrix_column_0, i);
            m[1][i] = lane_value(w.matrix_column_1, i);
            m[2][i] = lane_value(w.matrix_column_2, i);
            t[i]    = lane_value(w.translation_column, i);
            c[i]    = lane_value(w.sphere_center, i);
        end
        for (int i = 0; i < 3; i++) begin
            acc = t[i] * (64'sd1 <<< TB_MATRIX_FRAC);
            for (int j = 0; j < 3; j++) acc += m[j][i] * c[j];
            // round half toward plus infinity, arithmetic shift floors
            r = (acc + (64'sd1 <<< (TB_MATRIX_FRAC - 1))) >>> TB_MATRIX_FRAC;
            if (r > lane_max) begin
                r    = lane_max;
                clip = 1'b1;
            end
            if (r < lane_min) begin
                r    = lane_min;
                clip = 1'b1;
            end
            packed_ctr |= (64'(r) & lane_mask) << (i * TB_VALUE_WIDTH);
        end
        for (int j = 0; j < 3; j++) begin
            col_sq = 0;
            for (int i = 0; i < 3; i++) col_sq += 64'(m[j][i] * m[j][i]);
            if (col_sq > max_sq) max_sq = col_sq;
        end
        root = int_sqrt(max_sq << (2 * (ROOT_SCALE_BITS - TB_VALUE_WIDTH)));
        prod = root * 64'(w.sphere_radius);
        sh   = TB_MATRIX_FRAC + ROOT_SCALE_BITS - TB_VALUE_WIDTH;
        rad  = (prod + (64'd1 << (sh - 1))) >> sh;
        if (rad > 64'(RADIUS_MAX)) begin
            rad  = 64'(RADIUS_MAX);
            clip = 1'b1;
        end
        res.new_center = packed_ctr[FIELD_WIDTH-1:0];
        res.new_radius = rad[RADIUS_WIDTH-1:0];
        res.saturated  = clip;
        return res;
    endfunction

    // ---------------------------------------------------------------- scoreboard

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                pending_spheres.push_back(transform_sphere(in_if.data));
                spheres_sent++;
            end
            if (out_if.valid && out_if.ready) begin
                if (pending_spheres.size() == 0) begin
                    $display("%0t: result word with nothing pending: center %h radius %h sat %b",
                             $time, out_if.data.new_center, out_if.data.new_radius,
                             out_if.data.saturated);
                    mismatch_count++;
                end else begin
                    want = pending_spheres.pop_front();
                    spheres_checked++;
                    if (want.saturated) clipped_seen++;
                    if (out_if.data.new_center !== want.new_center) begin
                        $display("%0t: new_center expected %h actual %h",
                                 $time, want.new_center, out_if.data.new_center);
                        mismatch_count++;
                    end
                    if (out_if.data.new_radius !== want.new_radius) begin
                        $display("%0t: new_radius expected %h actual %h",
                                 $time, want.new_radius, out_if.data.new_radius);
                        mismatch_count++;
                    end
                    if (out_if.data.saturated !== want.saturated) begin
                        $display("%0t: saturated expected %b actual %b",
                                 $time, want.saturated, out_if.data.saturated);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d words still pending",
                     $time, cycle_count, pending_spheres.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- idling

    function automatic int idle_gap();
        int p;
        if (!idle_on) return 0;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        int unsigned hold_left;
        int          g;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_left = 0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD - 1;
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            g = idle_gap();
            if (g > 0) begin
                hold_left = g - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_sphere(input t_in_word w, input int gap);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= w;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    function automatic logic [FIELD_WIDTH-1:0] pack3(logic [15:0] a, logic [15:0] b,
                                                     logic [15:0] c);
        return {c, b, a};
    endfunction

    function automatic t_in_word make_sphere(logic [FIELD_WIDTH-1:0] c0,
                                             logic [FIELD_WIDTH-1:0] c1,
                                             logic [FIELD_WIDTH-1:0] c2,
                                             logic [FIELD_WIDTH-1:0] tr,
                                             logic [FIELD_WIDTH-1:0] ctr,
                                             logic [RADIUS_WIDTH-1:0] rad);
        t_in_word w;
        w.matrix_column_0    = c0;
        w.matrix_column_1    = c1;
        w.matrix_column_2    = c2;
        w.translation_column = tr;
        w.sphere_center      = ctr;
        w.sphere_radius      = rad;
        return w;
    endfunction

    function automatic logic [FIELD_WIDTH-1:0] any_field();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[FIELD_WIDTH-1:0];
    endfunction

    function automatic logic [15:0] edge_lane();
        case ($urandom_range(0, 6))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'h0001;
            5: return 16'h1000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] modest_lane(int span);
        int v;
        v = int'($urandom_range(0, 2 * span)) - span;
        return 16'(v);
    endfunction

    function automatic t_in_word random_sphere();
        t_in_word w;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                // raw bits everywhere
                w = make_sphere(any_field(), any_field(), any_field(), any_field(),
                                any_field(), 16'($urandom));
            end
            3, 4: begin
                w = make_sphere(pack3(edge_lane(), edge_lane(), edge_lane()),
                                pack3(edge_lane(), edge_lane(), edge_lane()),
                                pack3(edge_lane(), edge_lane(), edge_lane()),
                                pack3(edge_lane(), edge_lane(), edge_lane()),
                                pack3(edge_lane(), edge_lane(), edge_lane()),
                                ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'($urandom));
            end
            default: begin
                // scene-like transforms: scales within about +-2, moderate coordinates
                w = make_sphere(pack3(modest_lane(8192), modest_lane(8192), modest_lane(8192)),
                                pack3(modest_lane(8192), modest_lane(8192), modest_lane(8192)),
                                pack3(modest_lane(8192), modest_lane(8192), modest_lane(8192)),
                                pack3(modest_lane(4096), modest_lane(4096), modest_lane(4096)),
                                pack3(modest_lane(8000), modest_lane(8000), modest_lane(8000)),
                                16'($urandom_range(0, 16384)));
            end
        endcase
        return w;
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        logic [FIELD_WIDTH-1:0] ex;
        logic [FIELD_WIDTH-1:0] ey;
        logic [FIELD_WIDTH-1:0] ez;
        logic [FIELD_WIDTH-1:0] zero3;
        ex    = pack3(16'h1000, 16'h0000, 16'h0000);
        ey    = pack3(16'h0000, 16'h1000, 16'h0000);
        ez    = pack3(16'h0000, 16'h0000, 16'h1000);
        zero3 = '0;
        send_sphere(make_sphere(zero3, zero3, zero3, zero3, zero3, 16'h0000), 0);
        send_sphere(make_sphere(zero3, zero3, zero3, zero3, '1, 16'hFFFF), 0);
        // identity keeps center and radius
        send_sphere(make_sphere(ex, ey, ez, zero3, pack3(16'h0018, 16'hFFDC, 16'h0030),
                                16'h0100), 0);
        send_sphere(make_sphere(ex, ey, ez, zero3, pack3(16'h7FFF, 16'h8000, 16'h0001),
                                16'hFFFF), 1);
        // translation pushes past the lane range both ways
        send_sphere(make_sphere(ex, ey, ez, pack3(16'h7FFF, 16'h7FFF, 16'h0001),
                                pack3(16'h7FFF, 16'h0001, 16'h7FFF), 16'h0200), 0);
        send_sphere(make_sphere(ex, ey, ez, pack3(16'h8000, 16'h8000, 16'hFFFF),
                                pack3(16'h8000, 16'hFFFF, 16'h8000), 16'h0200), 0);
        // most negative matrix against extreme centers
        send_sphere(make_sphere(pack3(16'h8000, 16'h8000, 16'h8000),
                                pack3(16'h8000, 16'h8000, 16'h8000),
                                pack3(16'h8000, 16'h8000, 16'h8000),
                                zero3, pack3(16'h7FFF, 16'h7FFF, 16'h7FFF), 16'h0001), 2);
        send_sphere(make_sphere(pack3(16'h8000, 16'h8000, 16'h8000),
                                pack3(16'h8000, 16'h8000, 16'h8000),
                                pack3(16'h8000, 16'h8000, 16'h8000),
                                pack3(16'h8000, 16'h8000, 16'h8000),
                                pack3(16'h8000, 16'h8000, 16'h8000), 16'hFFFF), 0);
        send_sphere(make_sphere(pack3(16'h7FFF, 16'h7FFF, 16'h7FFF),
                                pack3(16'h7FFF, 16'h7FFF, 16'h7FFF),
                                pack3(16'h7FFF, 16'h7FFF, 16'h7FFF),
                                pack3(16'h7FFF, 16'h7FFF, 16'h7FFF),
                                pack3(16'h8000, 16'h7FFF, 16'h8000), 16'hFFFF), 0);
        // big matrix, zero radius
        send_sphere(make_sphere(pack3(16'h7FFF, 16'h8000, 16'h7FFF), ey, ez, zero3,
                                zero3, 16'h0000), 0);
        // uniform scale 2: radius goes just past the limit and clips, and lands just below it
        send_sphere(make_sphere(pack3(16'h2000, 16'h0000, 16'h0000),
                                pack3(16'h0000, 16'h2000, 16'h0000),
                                pack3(16'h0000, 16'h0000, 16'h2000),
                                zero3, pack3(16'h0010, 16'h0020, 16'h0030), 16'h8000), 0);
        send_sphere(make_sphere(pack3(16'h2000, 16'h0000, 16'h0000),
                                pack3(16'h0000, 16'h2000, 16'h0000),
                                pack3(16'h0000, 16'h0000, 16'h2000),
                                zero3, zero3, 16'h7FFF), 0);
        // half-way rounding goes up for both signs
        send_sphere(make_sphere(pack3(16'h0800, 16'h0800, 16'h0800), zero3, zero3, zero3,
                                pack3(16'h0001, 16'h0000, 16'h0000), 16'h0101), 0);
        send_sphere(make_sphere(pack3(16'h0800, 16'h0800, 16'h0800), zero3, zero3, zero3,
                                pack3(16'hFFFF, 16'h0000, 16'h0000), 16'h0101), 3);
        send_sphere(make_sphere(pack3(16'h0800, 16'h0000, 16'h0000),
                                pack3(16'h0000, 16'h0800, 16'h0000),
                                pack3(16'h0000, 16'h0000, 16'h0800),
                                zero3, pack3(16'hFFFD, 16'h0003, 16'hFFFF), 16'h0003), 0);
        // quarter-turn about z with a non-uniform scale on one column
        send_sphere(make_sphere(pack3(16'h0000, 16'h1000, 16'h0000),
                                pack3(16'hF000, 16'h0000, 16'h0000),
                                pack3(16'h0000, 16'h0000, 16'h3000),
                                pack3(16'h0100, 16'hFF00, 16'h0040),
                                pack3(16'h0123, 16'hFEDC, 16'h0456), 16'h0480), 0);
        // largest column wins the radius
        send_sphere(make_sphere(pack3(16'h0400, 16'h0400, 16'h0400), ey,
                                pack3(16'hE000, 16'h1000, 16'h0000),
                                zero3, pack3(16'h0008, 16'h0008, 16'h0008), 16'h1234), 0);
        in_if.valid <= 1'b0;
    endtask

    task automatic test_random_traffic(input int count);
        for (int n = 0; n < count; n++) send_sphere(random_sphere(), idle_gap());
        in_if.valid <= 1'b0;
    endtask

    task automatic test_output_hold_off(input int count);
        long_hold_req = 1'b1;
        for (int n = 0; n < count; n++) send_sphere(random_sphere(), 0);
        in_if.valid <= 1'b0;
    endtask

    task automatic test_full_rate(input int count);
        idle_on = 1'b0;
        for (int n = 0; n < count; n++) send_sphere(random_sphere(), 0);
        in_if.valid <= 1'b0;
        idle_on = 1'b1;
    endtask

    initial begin
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        i_rst_n     <= 1'b0;
        idle_on       = 1'b1;
        long_hold_req = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_traffic(900);
        test_output_hold_off(100);
        test_random_traffic(400);
        test_full_rate(200);
        test_random_traffic(330);

        while (pending_spheres.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d spheres in %0d cycles, %0d results checked, %0d clipped",
                 spheres_sent, cycle_count, spheres_checked, clipped_seen);
        $display("directed edge cases, random and scene-like transforms, long output stall");
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
